// ===== rtl/escape_rle_encoder_assert.svh =====
// assertion macros used by the rtl top
`ifndef ESCAPE_RLE_ENCODER_ASSERT_SVH
`define ESCAPE_RLE_ENCODER_ASSERT_SVH

// same-cycle implication
`define ERLE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ERLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/erle_pkg.sv =====
package erle_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [0:0] REG_ESCAPE = 1'b0;

    localparam logic [7:0] COUNT_ESC_BYTE  = 8'hff;
    localparam int         COUNT_ONE_MAX   = 255;
    localparam int         GROUP_MAX       = 127;
    localparam int         GROUP_BITS      = 7;
    localparam int         SHORT_RUN_MAX   = 3;

    typedef struct packed {
        logic [7:0] a_value;
        logic       b_valid;
        logic [7:0] b_value;
    } run_pair_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ESC,
        ST_CNT,
        ST_FF,
        ST_GRP,
        ST_VAL,
        ST_PAIR_ESC,
        ST_PAIR_ZERO,
        ST_LIT
    } back_state_t;

endpackage

// ===== rtl/erle_fifo.sv =====
module erle_fifo #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/erle_front.sv =====
module erle_front #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [7:0]              data_byte,
    input  logic                    is_final,
    output logic                    q_push,
    output logic [COUNT_WIDTH-1:0]  q_len,
    output erle_pkg::run_pair_t     q_pair,
    output logic                    run_open
);

    logic [7:0]             prev_byte_reg;
    logic [7:0]             prev_byte_next;
    logic                   prev_valid_reg;
    logic                   prev_valid_next;
    logic [COUNT_WIDTH-1:0] run_len_reg;
    logic [COUNT_WIDTH-1:0] run_len_next;
    logic [COUNT_WIDTH-1:0] len_inc;
    logic                   same;

    assign run_open = prev_valid_reg;
    assign same     = prev_valid_reg && (data_byte == prev_byte_reg);
    assign len_inc  = (&run_len_reg) ? run_len_reg : run_len_reg + COUNT_WIDTH'(1);

    always_comb
    begin
        prev_byte_next  = prev_byte_reg;
        prev_valid_next = prev_valid_reg;
        run_len_next    = run_len_reg;
        q_push          = 1'b0;
        q_len           = run_len_reg;
        q_pair.a_value  = prev_byte_reg;
        q_pair.b_valid  = 1'b0;
        q_pair.b_value  = data_byte;
        if (accept)
        begin
            if (same)
            begin
                run_len_next = len_inc;
                if (is_final)
                begin
                    q_push = 1'b1;
                    q_len  = len_inc;
                end
            end
            else
            begin
                if (prev_valid_reg)
                begin
                    q_push         = 1'b1;
                    q_pair.b_valid = is_final;
                end
                else if (is_final)
                begin
                    q_push         = 1'b1;
                    q_len          = COUNT_WIDTH'(1);
                    q_pair.a_value = data_byte;
                end
                prev_byte_next  = data_byte;
                prev_valid_next = 1'b1;
                run_len_next    = COUNT_WIDTH'(1);
            end
            if (is_final)
            begin
                prev_byte_next  = '0;
                prev_valid_next = 1'b0;
                run_len_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_byte_reg  <= '0;
            prev_valid_reg <= 1'b0;
            run_len_reg    <= '0;
        end
        else
        begin
            prev_byte_reg  <= prev_byte_next;
            prev_valid_reg <= prev_valid_next;
            run_len_reg    <= run_len_next;
        end
    end

endmodule

// ===== rtl/erle_back.sv =====
module erle_back #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [7:0]              escape_byte,
    input  logic                    q_empty,
    input  logic [COUNT_WIDTH-1:0]  q_len,
    input  erle_pkg::run_pair_t     q_pair,
    output logic                    q_pop,
    input  logic                    pop,
    output logic                    empty,
    output logic [7:0]              code_byte,
    output logic                    last_of_run,
    output logic                    busy
);

    erle_pkg::back_state_t  state_reg;
    erle_pkg::back_state_t  state_next;
    logic [7:0]             value_reg;
    logic [7:0]             value_next;
    logic [COUNT_WIDTH-1:0] rem_reg;
    logic [COUNT_WIDTH-1:0] rem_next;
    logic                   b_pend_reg;
    logic                   b_pend_next;
    logic [7:0]             b_value_reg;
    logic [7:0]             b_value_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [7:0]             code_reg;
    logic [7:0]             code_next;
    logic                   last_reg;
    logic                   last_next;

    logic                   out_free;
    logic                   emit;
    logic                   run_done;
    logic [7:0]             emit_byte;
    logic                   ld;
    logic [7:0]             ld_value;
    logic [COUNT_WIDTH-1:0] ld_len;

    assign empty       = !out_valid_reg;
    assign code_byte   = code_reg;
    assign last_of_run = last_reg;
    assign busy        = (state_reg != erle_pkg::ST_IDLE);
    assign out_free    = !out_valid_reg || pop;

    always_comb
    begin
        state_next     = state_reg;
        value_next     = value_reg;
        rem_next       = rem_reg;
        b_pend_next    = b_pend_reg;
        b_value_next   = b_value_reg;
        out_valid_next = out_valid_reg;
        code_next      = code_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;
        emit           = 1'b0;
        run_done       = 1'b0;
        emit_byte      = '0;
        ld             = 1'b0;
        ld_value       = b_value_reg;
        ld_len         = COUNT_WIDTH'(1);

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        if (busy && out_free)
        begin
            emit = 1'b1;
            unique case (state_reg)
                erle_pkg::ST_ESC:
                begin
                    emit_byte = escape_byte;
                    if (rem_reg < COUNT_WIDTH'(erle_pkg::COUNT_ONE_MAX))
                    begin
                        state_next = erle_pkg::ST_CNT;
                    end
                    else
                    begin
                        rem_next   = rem_reg - COUNT_WIDTH'(erle_pkg::COUNT_ONE_MAX);
                        state_next = erle_pkg::ST_FF;
                    end
                end
                erle_pkg::ST_CNT:
                begin
                    emit_byte  = rem_reg[7:0];
                    state_next = erle_pkg::ST_VAL;
                end
                erle_pkg::ST_FF:
                begin
                    emit_byte  = erle_pkg::COUNT_ESC_BYTE;
                    state_next = erle_pkg::ST_GRP;
                end
                erle_pkg::ST_GRP:
                begin
                    if (rem_reg > COUNT_WIDTH'(erle_pkg::GROUP_MAX))
                    begin
                        emit_byte = {1'b0, rem_reg[6:0]};
                        rem_next  = rem_reg >> erle_pkg::GROUP_BITS;
                    end
                    else
                    begin
                        emit_byte  = {1'b1, rem_reg[6:0]};
                        state_next = erle_pkg::ST_VAL;
                    end
                end
                erle_pkg::ST_VAL:
                begin
                    emit_byte = value_reg;
                    run_done  = 1'b1;
                end
                erle_pkg::ST_PAIR_ESC:
                begin
                    emit_byte  = escape_byte;
                    state_next = erle_pkg::ST_PAIR_ZERO;
                end
                erle_pkg::ST_PAIR_ZERO:
                begin
                    emit_byte = '0;
                    rem_next  = rem_reg - COUNT_WIDTH'(1);
                    if (rem_reg == COUNT_WIDTH'(1))
                    begin
                        run_done = 1'b1;
                    end
                    else
                    begin
                        state_next = erle_pkg::ST_PAIR_ESC;
                    end
                end
                erle_pkg::ST_LIT:
                begin
                    emit_byte = value_reg;
                    rem_next  = rem_reg - COUNT_WIDTH'(1);
                    if (rem_reg == COUNT_WIDTH'(1))
                    begin
                        run_done = 1'b1;
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end

        if (run_done)
        begin
            state_next = erle_pkg::ST_IDLE;
        end

        // load the next run as soon as the current one finishes
        if (!busy || run_done)
        begin
            if (b_pend_reg)
            begin
                ld          = 1'b1;
                b_pend_next = 1'b0;
            end
            else if (!q_empty)
            begin
                ld           = 1'b1;
                q_pop        = 1'b1;
                ld_value     = q_pair.a_value;
                ld_len       = q_len;
                b_pend_next  = q_pair.b_valid;
                b_value_next = q_pair.b_value;
            end
        end

        if (ld)
        begin
            value_next = ld_value;
            if (ld_len > COUNT_WIDTH'(erle_pkg::SHORT_RUN_MAX))
            begin
                state_next = erle_pkg::ST_ESC;
                rem_next   = ld_len - COUNT_WIDTH'(erle_pkg::SHORT_RUN_MAX);
            end
            else if (ld_value == escape_byte)
            begin
                state_next = erle_pkg::ST_PAIR_ESC;
                rem_next   = ld_len;
            end
            else
            begin
                state_next = erle_pkg::ST_LIT;
                rem_next   = ld_len;
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            code_next      = emit_byte;
            last_next      = run_done && !b_pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= erle_pkg::ST_IDLE;
            b_pend_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            b_pend_reg    <= b_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        rem_reg     <= rem_next;
        b_value_reg <= b_value_next;
        code_reg    <= code_next;
        last_reg    <= last_next;
    end

endmodule

// ===== rtl/escape_rle_encoder.sv =====
// channel   | handshake                    | payload
// ----------+------------------------------+--------------------------
// input     | push / full                  | data_byte, is_final
// result    | empty / pop                  | code_byte, last_of_run
// config    | psel penable pwrite pready   | paddr, pwdata, prdata
//
// one input byte is taken per cycle while the run queue has room
// the serializer sends one result byte per cycle unless the result side stalls
// a short run of n bytes gives n bytes, or n escape-zero pairs for the escape byte
// the output register and the run queue let both sides stall independently
// reset is asynchronous and clears the run state, the queue and the escape byte
`include "escape_rle_encoder_assert.svh"

module escape_rle_encoder #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      data_byte,
    input  logic                            is_final,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      code_byte,
    output logic                            last_of_run,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [erle_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [erle_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [erle_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int PAIR_W  = $bits(erle_pkg::run_pair_t);
    localparam int ENTRY_W = COUNT_WIDTH + PAIR_W;

    logic [7:0]             escape_reg;
    logic [7:0]             escape_next;
    logic                   cfg_wr;
    logic [0:0]             reg_idx;

    logic                   accept;
    logic                   q_push;
    logic                   q_pop;
    logic                   q_full;
    logic                   q_empty;
    logic [COUNT_WIDTH-1:0] push_len;
    erle_pkg::run_pair_t    push_pair;
    logic [ENTRY_W-1:0]     head;
    logic [COUNT_WIDTH-1:0] head_len;
    erle_pkg::run_pair_t    head_pair;
    logic                   run_open;
    logic                   back_busy;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        escape_next = escape_reg;
        prdata      = '0;
        unique case (reg_idx)
            erle_pkg::REG_ESCAPE:
            begin
                prdata = {{(erle_pkg::CFG_DATA_W - 8){1'b0}}, escape_reg};
                if (cfg_wr)
                begin
                    escape_next = pwdata[7:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg <= '0;
        end
        else
        begin
            escape_reg <= escape_next;
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    erle_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .data_byte(data_byte),
        .is_final (is_final),
        .q_push   (q_push),
        .q_len    (push_len),
        .q_pair   (push_pair),
        .run_open (run_open)
    );

    erle_fifo #(
        .WIDTH(ENTRY_W),
        .DEPTH(erle_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_data({push_len, push_pair}),
        .rd_en  (q_pop),
        .rd_data(head),
        .full   (q_full),
        .empty  (q_empty)
    );

    assign head_len  = head[ENTRY_W-1:PAIR_W];
    assign head_pair = erle_pkg::run_pair_t'(head[PAIR_W-1:0]);

    erle_back #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .escape_byte(escape_reg),
        .q_empty    (q_empty),
        .q_len      (head_len),
        .q_pair     (head_pair),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .code_byte  (code_byte),
        .last_of_run(last_of_run),
        .busy       (back_busy)
    );

    // the front never writes into a full queue
    `ERLE_ASSERT_IMPL(a_queue_no_overflow, clk, rst_n, q_push, !q_full)
    // a final byte closes the open run
    `ERLE_ASSERT_NEXT(a_final_closes_run, clk, rst_n, accept && is_final, !run_open)
    // an idle serializer picks up a waiting run at once
    `ERLE_ASSERT_NEXT(a_back_picks_up, clk, rst_n, !q_empty && !back_busy, back_busy)

endmodule
